// ----- rtl/core/octree_level_cell_statistics_macros.svh -----
// assertion macros shared by the checker files
// every property is clocked on i_clk and disabled while i_rst_n is low
`ifndef OCTREE_LEVEL_CELL_STATISTICS_MACROS_SVH
`define OCTREE_LEVEL_CELL_STATISTICS_MACROS_SVH

// same-cycle implication
`define OCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ocs_pkg.sv -----
`default_nettype none

package ocs_pkg;

    // octree shape and count saturation
    localparam int TREE_DEPTH  = 21;
    localparam int COUNT_BITS  = 24;
    localparam int LEVEL_SHIFT = 3;

    // fixed field widths
    localparam int KEY_W  = 63;
    localparam int LVL_W  = 5;
    localparam int CNT_OW = 25;
    localparam int SQ_W   = 49;

    // internal widths, one above the saturation cap
    localparam int CNT_IW = COUNT_BITS + 1;
    localparam int SQ_IW  = 2 * COUNT_BITS + 1;

    localparam logic [CNT_IW-1:0] CNT_CAP = {1'b1, {COUNT_BITS{1'b0}}};
    localparam logic [SQ_IW-1:0]  SQ_CAP  = {1'b1, {(2 * COUNT_BITS){1'b0}}};
    localparam logic [CNT_IW-1:0] CNT_ONE = CNT_IW'(1);
    localparam logic [SQ_IW-1:0]  SQ_ONE  = SQ_IW'(1);
    localparam logic [LVL_W-1:0]  LVL_LAST = LVL_W'(TREE_DEPTH);

    typedef struct packed {
        logic [KEY_W-1:0] point_key;
        logic             last_key;
    } t_in_beat;

    typedef struct packed {
        logic [LVL_W-1:0]  tree_level;
        logic [CNT_OW-1:0] occupied_cells;
        logic [CNT_OW-1:0] largest_population;
        logic [SQ_W-1:0]   square_sum;
        logic [CNT_OW-1:0] total_points;
        logic              final_result;
    } t_out_beat;

    // count to output field width
    function automatic logic [CNT_OW-1:0] f_cnt_out(input logic [CNT_IW-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[CNT_OW-1:0];
    endfunction

    // square sum to output field width
    function automatic logic [SQ_W-1:0] f_sq_out(input logic [SQ_IW-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[SQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/octree_level_cell_statistics.sv -----
// Octree per-level cell occupancy statistics over a sorted Morton key stream.
// Input channel (i_in_valid / o_in_ready / i_in_data): one key per beat, in
// ascending order; last_key marks the final key of a set (a set has >= 1 key).
// Output channel (o_out_valid / i_out_ready / o_out_data): after the marked
// key, 22 beats, levels 0..21 in order, final_result set on
// the deepest level.
// Throughput: one key per cycle while no marked key waits on a busy bank.
// All levels compare their prefix and update their run, cell, peak and
// square-sum registers in parallel in one stage. A marked key passes the input
// register, then statistics update with drain bank load, then output register;
// the result beats follow one per cycle while the receiver takes them.
// On the marked key the statistics are copied to a drain bank and the
// accumulators restart, so the next set streams in while results drain.
// A second marked key waits in the input register until the bank is drained.
// Receiver stall holds the output register; the input keeps flowing until a
// marked key meets a busy bank.
// Reset (synchronous, active low) drops all valid flags and arms the first-key
// load; no clearing pass is needed.
`default_nettype none

module octree_level_cell_statistics import ocs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    // input register
    logic     r_in_valid;
    t_in_beat r_in;

    // per-level accumulators
    logic [KEY_W-1:0]  r_prior [TREE_DEPTH];
    logic [CNT_IW-1:0] r_run   [TREE_DEPTH];
    logic [CNT_IW-1:0] r_cells [TREE_DEPTH];
    logic [CNT_IW-1:0] r_peak  [TREE_DEPTH];
    logic [SQ_IW-1:0]  r_sq    [TREE_DEPTH];
    logic [KEY_W-1:0]  n_prior [TREE_DEPTH];
    logic [CNT_IW-1:0] n_run   [TREE_DEPTH];
    logic [CNT_IW-1:0] n_cells [TREE_DEPTH];
    logic [CNT_IW-1:0] n_peak  [TREE_DEPTH];
    logic [SQ_IW-1:0]  n_sq    [TREE_DEPTH];
    logic [CNT_IW-1:0] r_points, n_points;
    logic [SQ_W-1:0]   r_sq0, n_sq0;
    logic              r_first;

    // drain bank
    logic [CNT_IW-1:0] r_snap_cells [TREE_DEPTH];
    logic [CNT_IW-1:0] r_snap_peak  [TREE_DEPTH];
    logic [SQ_IW-1:0]  r_snap_sq    [TREE_DEPTH];
    logic [CNT_IW-1:0] r_snap_points;
    logic [SQ_W-1:0]   r_snap_sq0;
    logic              r_busy;
    logic [LVL_W-1:0]  r_lvl;

    // output register
    logic      r_out_valid;
    t_out_beat r_out, n_out;

    logic proc;
    logic load;

    // a marked key may only proceed when the drain bank is free
    assign proc       = r_in_valid && (!r_in.last_key || !r_busy);
    assign o_in_ready = !r_in_valid || proc;
    assign load       = r_busy && (!r_out_valid || i_out_ready);

    // per-level prefix compare and statistics update
    always_comb begin
        logic [KEY_W-1:0]  pre;
        logic [SQ_IW:0]    sum;
        for (int i = 0; i < TREE_DEPTH; i++) begin
            pre        = r_in.point_key >> (LEVEL_SHIFT * (TREE_DEPTH - 1 - i));
            n_prior[i] = r_prior[i];
            n_run[i]   = r_run[i];
            n_cells[i] = r_cells[i];
            n_sq[i]    = r_sq[i];
            sum        = '0;
            if (r_first) begin
                n_prior[i] = pre;
                n_run[i]   = CNT_ONE;
                n_cells[i] = CNT_ONE;
                n_sq[i]    = SQ_ONE;
            end else if (pre == r_prior[i]) begin
                // run grows by one: square sum gains 2p+1
                if (r_run[i] < CNT_CAP) begin
                    sum      = {1'b0, r_sq[i]} + (SQ_IW + 1)'({r_run[i], 1'b1});
                    n_sq[i]  = (sum >= {1'b0, SQ_CAP}) ? SQ_CAP : sum[SQ_IW-1:0];
                    n_run[i] = r_run[i] + CNT_ONE;
                end
            end else begin
                // new cell
                n_prior[i] = pre;
                n_cells[i] = (r_cells[i] >= CNT_CAP) ? CNT_CAP : r_cells[i] + CNT_ONE;
                n_run[i]   = CNT_ONE;
                sum        = {1'b0, r_sq[i]} + (SQ_IW + 1)'(1);
                n_sq[i]    = (sum >= {1'b0, SQ_CAP}) ? SQ_CAP : sum[SQ_IW-1:0];
            end
            n_peak[i] = (r_first || n_run[i] > r_peak[i]) ? n_run[i] : r_peak[i];
        end
    end

    // root level: point count and its square, grown incrementally
    always_comb begin
        if (r_first) begin
            n_points = CNT_ONE;
            n_sq0    = SQ_W'(1);
        end else if (r_points < CNT_CAP) begin
            n_points = r_points + CNT_ONE;
            n_sq0    = r_sq0 + SQ_W'({r_points, 1'b1});
        end else begin
            n_points = r_points;
            n_sq0    = r_sq0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // accumulators, restarted after a marked key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (proc) begin
            r_first <= r_in.last_key;
        end
        if (proc) begin
            for (int i = 0; i < TREE_DEPTH; i++) begin
                r_prior[i] <= n_prior[i];
                r_run[i]   <= n_run[i];
                r_cells[i] <= n_cells[i];
                r_peak[i]  <= n_peak[i];
                r_sq[i]    <= n_sq[i];
            end
            r_points <= n_points;
            r_sq0    <= n_sq0;
        end
    end

    // drain bank: loaded on a marked key, shifted one level per output beat after the root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_lvl  <= '0;
        end else if (proc && r_in.last_key) begin
            r_busy <= 1'b1;
            r_lvl  <= '0;
        end else if (load) begin
            r_lvl <= r_lvl + LVL_W'(1);
            if (r_lvl == LVL_LAST) begin
                r_busy <= 1'b0;
            end
        end
        if (proc && r_in.last_key) begin
            for (int i = 0; i < TREE_DEPTH; i++) begin
                r_snap_cells[i] <= n_cells[i];
                r_snap_peak[i]  <= n_peak[i];
                r_snap_sq[i]    <= n_sq[i];
            end
            r_snap_points <= n_points;
            r_snap_sq0    <= n_sq0;
        end else if (load && r_lvl != '0) begin
            for (int i = 0; i < TREE_DEPTH - 1; i++) begin
                r_snap_cells[i] <= r_snap_cells[i+1];
                r_snap_peak[i]  <= r_snap_peak[i+1];
                r_snap_sq[i]    <= r_snap_sq[i+1];
            end
        end
    end

    // result beat for the current level
    always_comb begin
        n_out.tree_level   = r_lvl;
        n_out.total_points = f_cnt_out(r_snap_points);
        n_out.final_result = (r_lvl == LVL_LAST);
        if (r_lvl == '0) begin
            n_out.occupied_cells     = CNT_OW'(1);
            n_out.largest_population = f_cnt_out(r_snap_points);
            n_out.square_sum         = r_snap_sq0;
        end else begin
            n_out.occupied_cells     = f_cnt_out(r_snap_cells[0]);
            n_out.largest_population = f_cnt_out(r_snap_peak[0]);
            n_out.square_sum         = f_sq_out(r_snap_sq[0]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/ocs_checker.sv -----
`default_nettype none

`include "octree_level_cell_statistics_macros.svh"

module ocs_checker import ocs_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_beat  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_beat o_out_data
);

    // a stalled result beat holds
    `OCS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result beat changed while stalled")

    // levels step by one inside a run of results
    `OCS_ASSERT_NEXT(a_lvl_step, o_out_valid && i_out_ready && !o_out_data.final_result, o_out_valid && o_out_data.tree_level == $past(o_out_data.tree_level) + LVL_W'(1), "result levels out of sequence")

    // final flag exactly on the deepest level
    `OCS_ASSERT_NOW(a_final_lvl, o_out_valid, o_out_data.final_result == (o_out_data.tree_level == LVL_LAST), "final flag on wrong level")

    // root holds all points in one cell; no cell holds more than all points
    `OCS_ASSERT_NOW(a_root, o_out_valid && o_out_data.tree_level == '0, o_out_data.occupied_cells == CNT_OW'(1) && o_out_data.largest_population == o_out_data.total_points, "root level statistics wrong")
    `OCS_ASSERT_NOW(a_bounds, o_out_valid, o_out_data.occupied_cells != '0 && o_out_data.largest_population <= o_out_data.total_points && o_out_data.occupied_cells <= o_out_data.total_points, "cell statistics out of bounds")

endmodule

bind octree_level_cell_statistics ocs_checker u_ocs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ----- tb/sv/tb_octree_level_cell_statistics.sv -----
module tb_octree_level_cell_statistics;
    timeunit 1ns;
    timeprecision 1ps;

    import ocs_pkg::*;

    localparam int RUN_KEYS    = 440;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 12;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    typedef struct {
        t_in_beat    beat;
        int unsigned gap;
        bit          drain_first;
    } t_key_beat;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_beat  in_data  = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_data;

    t_key_beat pend_q[$];
    t_out_beat stats_due[$];

    // per-level statistics of the set being collected
    logic [KEY_W-1:0]  prev_prefix [1:TREE_DEPTH];
    logic [CNT_IW-1:0] run_len     [1:TREE_DEPTH];
    logic [CNT_IW-1:0] cell_cnt    [1:TREE_DEPTH];
    logic [CNT_IW-1:0] peak_pop    [1:TREE_DEPTH];
    logic [SQ_IW-1:0]  sq_total    [1:TREE_DEPTH];
    logic [CNT_IW-1:0] key_cnt;
    bit                first_pending;

    bit quiet_tx;
    bit rx_quiet;
    int tx_idle;
    int rx_stall;
    int mismatches;
    int keys_taken;
    int sets_closed;
    int results_seen;
    int directed_keys;
    int cycle_cnt;

    octree_level_cell_statistics dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reset
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // saturating count increment
    function automatic logic [CNT_IW-1:0] cnt_inc(input logic [CNT_IW-1:0] x);
        return (x >= CNT_CAP) ? CNT_CAP : x + CNT_ONE;
    endfunction

    // saturating square sum add
    function automatic logic [SQ_IW-1:0] sq_add(input logic [SQ_IW-1:0] a,
                                                input logic [SQ_IW:0] b);
        if (a >= SQ_CAP || b >= {1'b0, SQ_CAP - a})
            return SQ_CAP;
        return SQ_IW'(a + b);
    endfunction

    task automatic clear_set_stats();
        for (int lv = 1; lv <= TREE_DEPTH; lv++) begin
            prev_prefix[lv] = '0;
            run_len[lv]     = '0;
            cell_cnt[lv]    = '0;
            peak_pop[lv]    = '0;
            sq_total[lv]    = '0;
        end
        key_cnt       = '0;
        first_pending = 1'b1;
    endtask

    // fold one key into every level, queue the level results on a marked key
    task automatic accumulate_key(input t_in_beat b);
        logic [KEY_W-1:0]  pfx;
        logic [CNT_IW-1:0] p;
        logic [63:0]       sq0;
        t_out_beat         r;
        for (int lv = 1; lv <= TREE_DEPTH; lv++) begin
            pfx = b.point_key >> (LEVEL_SHIFT * (TREE_DEPTH - lv));
            if (first_pending) begin
                prev_prefix[lv] = pfx;
                run_len[lv]     = CNT_ONE;
                cell_cnt[lv]    = CNT_ONE;
                sq_total[lv]    = SQ_ONE;
            end else if (pfx == prev_prefix[lv]) begin
                p = run_len[lv];
                if (p < CNT_CAP) begin
                    // (p+1)^2 - p^2 = 2p+1
                    sq_total[lv] = sq_add(sq_total[lv], (SQ_IW + 1)'({p, 1'b1}));
                    run_len[lv]  = p + CNT_ONE;
                end
            end else begin
                prev_prefix[lv] = pfx;
                cell_cnt[lv]    = cnt_inc(cell_cnt[lv]);
                run_len[lv]     = CNT_ONE;
                sq_total[lv]    = sq_add(sq_total[lv], (SQ_IW + 1)'(1));
            end
            if (first_pending || run_len[lv] > peak_pop[lv])
                peak_pop[lv] = run_len[lv];
        end
        key_cnt       = first_pending ? CNT_ONE : cnt_inc(key_cnt);
        first_pending = 1'b0;

        if (b.last_key) begin
            // root level is one cell holding every key
            sq0                  = 64'(key_cnt) * 64'(key_cnt);
            r.tree_level         = '0;
            r.occupied_cells     = CNT_OW'(1);
            r.largest_population = key_cnt;
            r.square_sum         = sq0[SQ_W-1:0];
            r.total_points       = key_cnt;
            r.final_result       = 1'b0;
            stats_due.insert(stats_due.size(), r);
            for (int lv = 1; lv <= TREE_DEPTH; lv++) begin
                r.tree_level         = LVL_W'(lv);
                r.occupied_cells     = cell_cnt[lv];
                r.largest_population = peak_pop[lv];
                r.square_sum         = sq_total[lv];
                r.total_points       = key_cnt;
                r.final_result       = (lv == TREE_DEPTH);
                stats_due.insert(stats_due.size(), r);
            end
            sets_closed++;
            clear_set_stats();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[KEY_W-1:0];
    endfunction

    task automatic queue_key(input logic [KEY_W-1:0] key, input bit last,
                             input bit drain);
        t_key_beat kb;
        kb.beat.point_key = key;
        kb.beat.last_key  = last;
        kb.gap            = quiet_tx ? 0 : $urandom_range(0, 19);
        kb.drain_first    = drain;
        pend_q.insert(pend_q.size(), kb);
    endtask

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_idle = 0;
        end else begin
            if (in_valid && in_ready) begin
                accumulate_key(in_data);
                keys_taken++;
                tx_idle = (pend_q.size() != 0) ? pend_q[0].gap : 0;
            end
            if (!in_valid || in_ready) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                    in_valid <= 1'b0;
                end else if (pend_q.size() == 0 ||
                             (pend_q[0].drain_first && stats_due.size() != 0)) begin
                    in_valid <= 1'b0;
                end else begin
                    in_data  <= pend_q[0].beat;
                    in_valid <= 1'b1;
                    pend_q.delete(0);
                end
            end
        end
    end

    // result monitor with random receiver stalls
    always @(posedge clk) begin
        t_out_beat want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (stats_due.size() == 0) begin
                    $error("result beat with nothing expected, tree_level %0d",
                           out_data.tree_level);
                    mismatches++;
                end else begin
                    want = stats_due.pop_front();
                    check_field("tree_level", 64'(want.tree_level),
                                64'(out_data.tree_level));
                    check_field("occupied_cells", 64'(want.occupied_cells),
                                64'(out_data.occupied_cells));
                    check_field("largest_population", 64'(want.largest_population),
                                64'(out_data.largest_population));
                    check_field("square_sum", 64'(want.square_sum),
                                64'(out_data.square_sum));
                    check_field("total_points", 64'(want.total_points),
                                64'(out_data.total_points));
                    check_field("final_result", 64'(want.final_result),
                                64'(out_data.final_result));
                    results_seen++;
                end
                rx_stall = rx_quiet ? 0 : $urandom_range(0, 19);
                if ($urandom_range(0, 63) == 0)
                    rx_quiet = !rx_quiet;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int               set_len;
        int               rand_keys;
        int               total_keys;
        int               k;
        int               d;
        int               pick;
        bit               scramble;
        logic [KEY_W-1:0] key;
        logic [63:0]      nxt;

        clear_set_stats();
        quiet_tx = 1'b0;
        rx_quiet = 1'b0;

        // single key sets at both key extremes, the second waits for a drained output
        queue_key('0, 1'b1, 1'b0);
        queue_key(KEY_MAX, 1'b1, 1'b1);

        // ascending set with repeats and carries across every level boundary
        queue_key(63'd0, 1'b0, 1'b0);
        queue_key(63'd0, 1'b0, 1'b0);
        queue_key(63'd7, 1'b0, 1'b0);
        queue_key(63'd8, 1'b0, 1'b0);
        queue_key(63'd63, 1'b0, 1'b0);
        queue_key(63'd64, 1'b0, 1'b0);
        queue_key((63'd1 << 60) - 63'd1, 1'b0, 1'b0);
        queue_key(63'd1 << 60, 1'b0, 1'b0);
        queue_key(KEY_MAX - 63'd1, 1'b0, 1'b0);
        queue_key(KEY_MAX, 1'b0, 1'b0);
        queue_key(KEY_MAX, 1'b1, 1'b0);

        // keys out of order, a prefix coming back after another one
        quiet_tx = 1'b1;
        queue_key(63'd5, 1'b0, 1'b0);
        queue_key(63'd1 << 60, 1'b0, 1'b0);
        queue_key(63'd5, 1'b0, 1'b0);
        queue_key(63'd3, 1'b0, 1'b0);
        queue_key(63'd1 << 60, 1'b1, 1'b0);

        queue_key(rand_key(), 1'b1, 1'b0);
        directed_keys = pend_q.size();

        // random sets, mostly sorted with steps at random levels
        rand_keys = 0;
        while (rand_keys < RUN_KEYS) begin
            pick = $urandom_range(0, 15);
            if (pick < 2)
                set_len = 1;
            else if (pick < 14)
                set_len = $urandom_range(2, 16);
            else
                set_len = $urandom_range(17, 48);
            quiet_tx = ($urandom_range(0, 3) == 0);
            scramble = ($urandom_range(0, 9) == 0);
            key = rand_key();
            if ($urandom_range(0, 1) == 0)
                key = key >> $urandom_range(1, 8);
            for (int j = 0; j < set_len; j++) begin
                if (j > 0) begin
                    if (scramble) begin
                        key = rand_key();
                    end else begin
                        k = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 20);
                        d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                        nxt = 64'(key) + (64'(d) << (3 * k));
                        key = (nxt > 64'(KEY_MAX)) ? KEY_MAX : nxt[KEY_W-1:0];
                    end
                end
                queue_key(key, j == set_len - 1, j == 0 && $urandom_range(0, 7) == 0);
            end
            rand_keys += set_len;
        end
        total_keys = pend_q.size();

        // wait for every beat to be taken and every result to arrive
        @(posedge rst_n);
        while (keys_taken < total_keys)
            @(posedge clk);
        while (stats_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d keys (%0d directed) in %0d sets, %0d level results checked",
                 keys_taken, directed_keys, sets_closed, results_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
